FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/ppq_pkg.sv
`default_nettype none

package ppq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_W     = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_COUNT  = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_PLACE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       shift_up;
      logic       place;
      logic       pop_take;
      logic       count_inc;
      logic       set_status;
      logic [1:0] status;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       ins_move;
      logic       in_limit;
      logic       idx_one;
      logic       count_last;
      logic       rsp_free;
   } stat_type;

   function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [OCC_W-1:0] lidx);
      logic [OCC_W:0] sum;
      sum = (OCC_W+1)'(head) + (OCC_W+1)'(lidx);
      if (sum >= (OCC_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (OCC_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [OCC_W-1:0] cnt);
      logic [OCC_W+COUNT_W-1:0] wide;
      wide = (OCC_W+COUNT_W)'(cnt);
      if (wide > (OCC_W+COUNT_W)'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return wide[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/ppq_ram.sv
`default_nettype none

module ppq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/ppq_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module ppq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_op,
   output logic                   req_stall,
   input  wire ppq_pkg::stat_type stat,
   output ppq_pkg::cmd_type       cmd
);
   import ppq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_INSERT: begin
                     if (stat.full) begin
                        state_in = S_DONE;
                     end else if (stat.empty) begin
                        state_in = S_PLACE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_POP, OP_COUNT: state_in = stat.empty ? S_DONE : S_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.ins_move && !stat.idx_one) begin
                     state_in = S_READ;
                  end else begin
                     state_in = S_PLACE;
                  end
               end
               OP_COUNT: begin
                  if (stat.in_limit && !stat.count_last) begin
                     state_in = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PLACE: state_in = S_DONE;
         S_DONE: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (req_op)
                  OP_INSERT: begin
                     cmd.set_status = stat.full;
                     cmd.status     = ST_FULL;
                  end
                  OP_POP: begin
                     cmd.set_status = stat.empty;
                     cmd.status     = ST_NONE;
                  end
                  OP_COUNT: begin
                     cmd.set_status = stat.empty;
                     cmd.status     = ST_DONE;
                  end
                  default: begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NONE;
                  end
               endcase
            end
         end
         S_READ: begin
         end
         S_EVAL: begin
            unique case (stat.op)
               OP_INSERT: cmd.shift_up = stat.ins_move;
               OP_POP: begin
                  cmd.pop_take   = stat.in_limit;
                  cmd.set_status = 1'b1;
                  cmd.status     = stat.in_limit ? ST_DONE : ST_NONE;
               end
               OP_COUNT: begin
                  cmd.count_inc  = stat.in_limit;
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_DONE;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_NONE;
               end
            endcase
         end
         S_PLACE: begin
            cmd.place      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_DONE;
         end
         S_DONE: cmd.publish = stat.rsp_free;
         default: begin
         end
      endcase
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPL(a_place_room, clock, reset, cmd.place, !stat.full)

endmodule

`default_nettype wire

FILE: sv/ppq_dp.sv
`default_nettype none
`include "assert_macros.svh"

module ppq_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [1:0]                      req_op,
   input  wire logic [15:0]                     req_item_handle,
   input  wire logic [7:0]                      req_item_priority,
   input  wire logic [7:0]                      req_priority_limit,
   input  wire ppq_pkg::cmd_type                cmd,
   output ppq_pkg::stat_type                    stat,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [15:0]                          rsp_popped_handle,
   output logic [ppq_pkg::COUNT_W-1:0]          rsp_eligible_count
);
   import ppq_pkg::*;

   logic [1:0]         op_ff, op_in;
   logic [15:0]        handle_ff, handle_in;
   logic [7:0]         prio_ff, prio_in;
   logic [7:0]         limit_ff, limit_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   idx_ff, idx_in;
   logic [OCC_W-1:0]   count_ff, count_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [15:0]        res_handle_ff, res_handle_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_handle_ff, rsp_handle_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [OCC_W-1:0]   rd_lidx;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               wr_en;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic [OCC_W:0]     idx_next;

   assign rd_lidx  = (op_ff == OP_INSERT && idx_ff != '0) ? idx_ff - OCC_W'(1) : idx_ff;
   assign rd_addr  = phys_addr(head_ff, rd_lidx);
   assign wr_addr  = phys_addr(head_ff, idx_ff);
   assign wr_en    = cmd.shift_up || cmd.place;
   assign rd_entry = entry_type'(rd_word);
   assign idx_next = (OCC_W+1)'(idx_ff) + (OCC_W+1)'(1);

   always_comb begin
      if (cmd.shift_up) begin
         wr_entry = rd_entry;
      end else begin
         wr_entry.prio   = prio_ff;
         wr_entry.handle = handle_ff;
      end
   end

   ppq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   always_comb begin
      stat.op         = op_ff;
      stat.full       = (occ_ff == OCC_W'(QUEUE_DEPTH));
      stat.empty      = (occ_ff == '0);
      stat.ins_move   = (rd_entry.prio >= prio_ff);
      stat.in_limit   = (rd_entry.prio <= limit_ff);
      stat.idx_one    = (idx_ff == OCC_W'(1));
      stat.count_last = (idx_next == (OCC_W+1)'(occ_ff));
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      op_in         = op_ff;
      handle_in     = handle_ff;
      prio_in       = prio_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         op_in         = req_op;
         handle_in     = req_item_handle;
         prio_in       = req_item_priority;
         limit_in      = req_priority_limit;
         idx_in        = (req_op == OP_INSERT) ? occ_ff : '0;
         count_in      = '0;
         res_handle_in = '0;
      end
      if (cmd.shift_up) begin
         idx_in = idx_ff - OCC_W'(1);
      end
      if (cmd.place) begin
         occ_in = occ_ff + OCC_W'(1);
      end
      if (cmd.pop_take) begin
         head_in       = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
         occ_in        = occ_ff - OCC_W'(1);
         res_handle_in = rd_entry.handle;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + OCC_W'(1);
         idx_in   = idx_next[OCC_W-1:0];
      end
      if (cmd.set_status) begin
         res_status_in = cmd.status;
      end
      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_handle_in = res_handle_ff;
         rsp_count_in  = sat_count(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      prio_ff       <= prio_in;
      limit_ff      <= limit_in;
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_popped_handle  = rsp_handle_ff;
   assign rsp_eligible_count = rsp_count_ff;

   `ASSERT_IMPL(a_occ_range, clock, reset, 1'b1, occ_ff <= OCC_W'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_pop_shrinks, clock, reset, cmd.pop_take, occ_ff == $past(occ_ff) - OCC_W'(1))
   `ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid)

endmodule

`default_nettype wire

FILE: sv/priority_pending_queue_top.sv
// channel   direction  handshake             fields
// req       in         req_valid/req_stall   op, item_handle, item_priority, priority_limit
// rsp       out        rsp_valid/rsp_stall   status, popped_handle, eligible_count
//
// one item at a time; req_stall stays high from acceptance until the result is registered
// pop: accept, entry store read, compare, result load; an empty queue skips read and compare
// insert: from the tail, entries of equal or higher priority move up, then the item is placed
// count: reads entries from the head while they are within the limit; empty skips the reads
// synchronous reset empties the queue at once; store contents are not cleared
// a stalled result stays in the output register; the next item is taken meanwhile
`default_nettype none

module priority_pending_queue_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_op,
   input  wire logic [15:0]            req_item_handle,
   input  wire logic [7:0]             req_item_priority,
   input  wire logic [7:0]             req_priority_limit,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [15:0]                 rsp_popped_handle,
   output logic [ppq_pkg::COUNT_W-1:0] rsp_eligible_count
);
   import ppq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ppq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_op),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   ppq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_item_handle   (req_item_handle),
      .req_item_priority (req_item_priority),
      .req_priority_limit(req_priority_limit),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_handle (rsp_popped_handle),
      .rsp_eligible_count(rsp_eligible_count)
   );

endmodule

`default_nettype wire

FILE: dv/priority_pending_queue_checker.sv
`default_nettype none

module priority_pending_queue_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic [1:0]                  req_op,
   input  wire logic [15:0]                 req_item_handle,
   input  wire logic [7:0]                  req_item_priority,
   input  wire logic [7:0]                  req_priority_limit,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [1:0]                  rsp_status,
   input  wire logic [15:0]                 rsp_popped_handle,
   input  wire logic [ppq_pkg::COUNT_W-1:0] rsp_eligible_count,
   output int                               mismatches,
   output int                               awaited
);

   timeunit 1ns;
   timeprecision 1ps;

   import ppq_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        handle;
      logic [COUNT_W-1:0] count;
   } answer_type;

   logic [15:0] handle_line [QUEUE_DEPTH];
   logic [7:0]  rank_line   [QUEUE_DEPTH];
   int          fill;
   answer_type  answers [$];

   task automatic apply_request(input logic [1:0] op, input logic [15:0] handle,
                                input logic [7:0] rank, input logic [7:0] limit,
                                output answer_type ans);
      int slot;
      int k;
      int n;
      ans = '{status: ST_NONE, handle: '0, count: '0};
      case (op)
         OP_INSERT: begin
            if (fill >= QUEUE_DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               slot = 0;
               while (slot < fill && rank > rank_line[slot]) slot++;
               for (k = fill; k > slot; k--) begin
                  handle_line[k] = handle_line[k-1];
                  rank_line[k]   = rank_line[k-1];
               end
               handle_line[slot] = handle;
               rank_line[slot]   = rank;
               fill++;
               ans.status = ST_DONE;
            end
         end
         OP_POP: begin
            if (fill > 0 && rank_line[0] <= limit) begin
               ans.status = ST_DONE;
               ans.handle = handle_line[0];
               for (k = 1; k < fill; k++) begin
                  handle_line[k-1] = handle_line[k];
                  rank_line[k-1]   = rank_line[k];
               end
               fill--;
            end
         end
         OP_COUNT: begin
            n = 0;
            while (n < fill && rank_line[n] <= limit) n++;
            ans.status = ST_DONE;
            ans.count  = (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
         end
         default: begin
         end
      endcase
   endtask

   task automatic flag(input string note, input answer_type due, input answer_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%t %s: status %0d/%0d handle %h/%h count %0d/%0d (expected/actual)",
                  $realtime, note, due.status, seen.status, due.handle, seen.handle,
                  due.count, seen.count);
      end
   endtask

   always @(posedge clock) begin
      answer_type seen;
      answer_type due;
      if (reset) begin
         fill = 0;
         answers.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{status: rsp_status, handle: rsp_popped_handle, count: rsp_eligible_count};
            if (answers.size() == 0) begin
               flag("result with nothing pending", seen, seen);
            end else begin
               due = answers.pop_front();
               if (due !== seen) flag("result mismatch", due, seen);
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_op, req_item_handle, req_item_priority, req_priority_limit, due);
            answers.push_back(due);
         end
      end
      awaited = answers.size();
   end

endmodule

`default_nettype wire

FILE: dv/priority_pending_queue_top_tb.sv
`default_nettype none

module priority_pending_queue_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import ppq_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         RANDOM_ITEMS = 1600;
   localparam int         HOLD_CYCLES  = 400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [15:0]        req_item_handle;
   logic [7:0]         req_item_priority;
   logic [7:0]         req_priority_limit;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_popped_handle;
   logic [COUNT_W-1:0] rsp_eligible_count;
   int                 mismatches;
   int                 awaited;

   logic               hold_now;
   logic               hold_done;
   int                 burst_left;
   int                 issued;

   priority_pending_queue_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_item_handle    (req_item_handle),
      .req_item_priority  (req_item_priority),
      .req_priority_limit (req_priority_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_handle  (rsp_popped_handle),
      .rsp_eligible_count (rsp_eligible_count)
   );

   priority_pending_queue_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_item_handle    (req_item_handle),
      .req_item_priority  (req_item_priority),
      .req_priority_limit (req_priority_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_popped_handle  (rsp_popped_handle),
      .rsp_eligible_count (rsp_eligible_count),
      .mismatches         (mismatches),
      .awaited            (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("priority_pending_queue_top verification failed");
      $finish;
   end

   task automatic offer_request(input logic [1:0] op, input logic [15:0] handle,
                                input logic [7:0] rank, input logic [7:0] limit);
      @(negedge clock);
      req_valid          = 1'b1;
      req_op             = op;
      req_item_handle    = handle;
      req_item_priority  = rank;
      req_priority_limit = limit;
      do @(posedge clock); while (req_stall);
      issued++;
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid          = 1'b0;
         req_item_handle    = 16'($urandom);
         req_item_priority  = 8'($urandom);
         req_priority_limit = 8'($urandom);
      end
   endtask

   // bursts of random length, sometimes long stretches with no gaps
   task automatic pace();
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   function automatic logic [7:0] pick_rank(input bit ties);
      return ties ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_limit();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'hff;
      if (r < 50) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // receiver: changing stall patterns plus one long hold-off
   initial begin
      int unsigned mode;
      int unsigned tick;
      int          held;
      rsp_stall = 1'b0;
      hold_done = 1'b0;
      mode      = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_now && !hold_done) begin
            rsp_stall = 1'b1;
            for (held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (tick % 48 == 0) mode = $urandom_range(0, 3);
            tick++;
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 99) < 30);
               2:       rsp_stall = ($urandom_range(0, 99) < 75);
               default: rsp_stall = (tick % 4 != 0);
            endcase
         end
      end
   end

   initial begin
      int          kind;
      int          seg_len;
      int unsigned r;
      bit          ties;
      logic [1:0]  op;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = OP_INSERT;
      req_item_handle    = '0;
      req_item_priority  = '0;
      req_priority_limit = '0;
      hold_now           = 1'b0;
      burst_left         = 0;
      issued             = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue, unused opcode
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'hff);
      offer_request(OP_COUNT, 16'($urandom), 8'($urandom), 8'hff);
      offer_request(OP_UNUSED, 16'hffff, 8'hff, 8'hff);
      // extremes and a tie at equal priority
      offer_request(OP_INSERT, 16'h0000, 8'h00, 8'($urandom));
      offer_request(OP_INSERT, 16'hffff, 8'hff, 8'($urandom));
      offer_request(OP_INSERT, 16'h1234, 8'h80, 8'($urandom));
      offer_request(OP_INSERT, 16'h5555, 8'h80, 8'($urandom));
      offer_request(OP_COUNT, 16'($urandom), 8'($urandom), 8'h00);
      offer_request(OP_COUNT, 16'($urandom), 8'($urandom), 8'h7f);
      offer_request(OP_COUNT, 16'($urandom), 8'($urandom), 8'hff);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'h00);
      // head above limit
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'h7f);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'h80);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'hfe);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'hfe);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'hff);
      offer_request(OP_POP, 16'($urandom), 8'($urandom), 8'h00);
      offer_request(OP_COUNT, 16'($urandom), 8'($urandom), 8'h00);

      // fill past full first, with the long receiver hold-off on top
      hold_now = 1'b1;
      issued   = 0;
      kind     = 0;
      seg_len  = 100;
      while (issued < RANDOM_ITEMS) begin
         ties = ($urandom_range(0, 1) == 1);
         repeat (seg_len) begin
            r = $urandom_range(0, 99);
            case (kind)
               0:       op = (r < 85) ? OP_INSERT : (r < 95) ? OP_COUNT : OP_POP;
               1:       op = (r < 75) ? OP_POP : (r < 90) ? OP_COUNT :
                             (r < 97) ? OP_INSERT : OP_UNUSED;
               default: op = (r < 40) ? OP_INSERT : (r < 75) ? OP_POP :
                             (r < 95) ? OP_COUNT : OP_UNUSED;
            endcase
            pace();
            offer_request(op, 16'($urandom), pick_rank(ties), pick_limit());
         end
         kind    = $urandom_range(0, 2);
         seg_len = $urandom_range(20, 80);
      end
      @(negedge clock);
      req_valid = 1'b0;

      wait (awaited == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("priority_pending_queue_top verification clean");
      end else begin
         $display("priority_pending_queue_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+sv
sv/ppq_pkg.sv
sv/ppq_ram.sv
sv/ppq_ctrl.sv
sv/ppq_dp.sv
sv/priority_pending_queue_top.sv
dv/priority_pending_queue_checker.sv
dv/priority_pending_queue_top_tb.sv
